>>> src/rra_pkg.sv
// ============================================================================
// rra_pkg
// Shared types, register codes and reset values of the ring resource arbiter.
// ============================================================================
package rra_pkg;

    // default parameter values
    localparam int MAX_RING_DEF  = 16;
    localparam int TIME_BITS_DEF = 32;

    // result limit per item
    localparam int MAX_RESULTS = 16;

    // field widths
    localparam int REQ_W      = 2;
    localparam int WHO_W      = 4;
    localparam int IDX_OUT_W  = 4;
    localparam int RES_TIME_W = 32;
    localparam int COOL_W     = 16;
    localparam int BURN_W     = 20;
    localparam int RING_W     = 5;
    localparam int COMP_W     = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BURNOUT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_LIMIT  = 3'd4;

    // register reset values
    localparam logic              RST_SCHED_MODE = 1'b0;
    localparam logic [COOL_W-1:0] RST_COOLDOWN   = 16'd0;
    localparam logic [BURN_W-1:0] RST_BURNOUT    = 20'd800;
    localparam logic [RING_W-1:0] RST_RING_SIZE  = 5'd5;
    localparam logic [COMP_W-1:0] RST_COMP_LIMIT = 8'd255;

    // item kinds
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACQUIRE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [WHO_W-1:0] requester_index;
    } t_cmd;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]  granted_index;
        logic [RES_TIME_W-1:0] grant_time;
        logic                  is_last;
    } t_result;

    // status a cell shows its neighbors
    typedef struct packed {
        logic waiting;
        logic holding;
        logic cooled;
    } t_cell_stat;

    // per-cell strobes from the controller
    typedef struct packed {
        logic req;
        logic rel;
        logic free;
        logic take;
        logic single;
        logic grant_en;
        logic is_end;
    } t_cell_ctl;

endpackage

>>> src/rra_cell.sv
// ============================================================================
// rra_cell
// One requester of the ring with the resource on its left side. Evaluates the
// grant while it holds the scan token, then hands the token to the next cell.
// ============================================================================
module rra_cell import rra_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic                 i_token,
    output logic                 o_token,
    input  logic                 i_sched_mode,
    input  logic [BURN_W-1:0]    i_burnout,
    input  logic [COMP_W-1:0]    i_comp_limit,
    input  logic [TIME_BITS-1:0] i_tick,
    input  logic [TIME_BITS-1:0] i_until,
    input  t_cell_stat           i_left_stat,
    input  t_cell_stat           i_right_stat,
    input  logic [TIME_BITS-1:0] i_left_key,
    input  logic [TIME_BITS-1:0] i_right_key,
    output t_cell_stat           o_stat,
    output logic [TIME_BITS-1:0] o_key,
    output logic                 o_grant
);

    localparam int SUM_W = ((TIME_BITS > BURN_W) ? TIME_BITS : BURN_W) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic                 r_token;
    logic                 r_waiting;
    logic                 r_holding;
    logic                 r_busy;
    logic [TIME_BITS-1:0] r_req_stamp;
    logic [TIME_BITS-1:0] r_grant_stamp;
    logic [TIME_BITS-1:0] r_free_at;
    logic [COMP_W-1:0]    r_count;

    logic [SUM_W-1:0]     dl_sum;
    logic [TIME_BITS-1:0] dl_key;
    logic                 cooled;
    logic                 beat_l;
    logic                 beat_r;
    logic                 acq_ok;

    // deadline key saturates at the top of the time range
    assign dl_sum = SUM_W'(r_grant_stamp) + SUM_W'(i_burnout);
    assign dl_key = (dl_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : dl_sum[TIME_BITS-1:0];
    assign o_key  = i_sched_mode ? dl_key : r_req_stamp;

    assign cooled = !r_busy && (i_tick >= r_free_at);
    assign beat_l = i_left_stat.waiting && (i_left_key < o_key);
    assign beat_r = i_right_stat.waiting && (i_right_key < o_key);

    assign o_grant = r_token && r_waiting && i_ctl.grant_en && cooled &&
                     i_right_stat.cooled && (i_ctl.single || (!beat_l && !beat_r));

    assign o_token = r_token && !i_ctl.is_end;
    assign o_stat  = '{waiting: r_waiting, holding: r_holding, cooled: cooled};

    assign acq_ok = i_ctl.req && !r_waiting && !r_holding && (r_count < i_comp_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token       <= 1'b0;
            r_waiting     <= 1'b0;
            r_holding     <= 1'b0;
            r_busy        <= 1'b0;
            r_grant_stamp <= '0;
            r_free_at     <= '0;
            r_count       <= '0;
        end else begin
            r_token <= i_token;
            if (acq_ok) begin
                r_waiting <= 1'b1;
            end else if (o_grant) begin
                r_waiting <= 1'b0;
            end
            // release is only strobed when this requester holds
            if (i_ctl.rel) begin
                r_holding <= 1'b0;
                if (r_count != '1) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (o_grant) begin
                r_holding <= 1'b1;
            end
            if (i_ctl.free) begin
                r_busy    <= 1'b0;
                r_free_at <= i_until;
            end else if (o_grant || i_ctl.take) begin
                r_busy <= 1'b1;
            end
            if (o_grant) begin
                r_grant_stamp <= i_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acq_ok) begin
            r_req_stamp <= i_tick;
        end
    end

endmodule

>>> src/ring_resource_arbiter.sv
// ============================================================================
// ring_resource_arbiter
// Operation: an accepted item is scanned along the token chain over the ring
// size in use, one cell per cycle, then passes a flush state; results strobe
// out during that walk and in the cycle after the flush. A new item is taken
// only in the idle state, after the flush; results cannot be stalled.
// Reset: synchronous, active low; flags, counts, grant stamps and release
// times clear at once; request stamps load on each accepted request.
// ============================================================================
module ring_resource_arbiter import rra_pkg::*; #(
    parameter int MAX_RING  = MAX_RING_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd                  i_cmd,
    output logic                  o_strobe,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W  = (MAX_RING > 1) ? $clog2(MAX_RING) : 1;
    localparam int N_W    = $clog2(MAX_RING + 1);
    localparam int CMP_W  = (N_W > RING_W) ? N_W : RING_W;
    localparam int GCNT_W = $clog2(MAX_RESULTS + 1);
    localparam int T_SUM_W = TIME_BITS + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]           r_state;
    logic [IDX_W-1:0]     r_scan_idx;
    logic [GCNT_W-1:0]    r_grants;
    logic [TIME_BITS-1:0] r_tick;
    logic                 r_sched_mode;
    logic [COOL_W-1:0]    r_cooldown;
    logic [BURN_W-1:0]    r_burnout;
    logic [RING_W-1:0]    r_ring_size;
    logic [COMP_W-1:0]    r_comp_limit;
    logic                 r_pend_valid;
    t_result              r_pend;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 accept;
    logic [CMP_W-1:0]     ring_ext;
    logic [CMP_W-1:0]     n_eff;
    logic [CMP_W-1:0]     last_cmp;
    logic [IDX_W-1:0]     last_idx;
    logic                 single;
    logic [CMP_W-1:0]     who_cmp;
    logic                 who_ok;
    logic [CMP_W-1:0]     b_cmp;
    logic [CMP_W-1:0]     scan_cmp;
    logic [CMP_W-1:0]     gb_cmp;
    logic                 scan_last;
    logic                 holding_sel;
    logic                 rel_ok;
    logic                 any_grant;
    logic                 grant_en;
    logic [T_SUM_W-1:0]   tick_sum;
    logic [T_SUM_W-1:0]   until_sum;
    logic [TIME_BITS-1:0] tick_inc;
    logic [TIME_BITS-1:0] cool_end;
    t_result              new_res;

    logic [MAX_RING-1:0]  who_hit;
    logic [MAX_RING-1:0]  holding_vec;
    logic [MAX_RING-1:0]  grant_vec;
    logic [MAX_RING-1:0]  token_out;
    t_cell_stat           stat_vec [MAX_RING];
    logic [TIME_BITS-1:0] key_vec  [MAX_RING];

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // clamp ring size to 1..MAX_RING
    assign ring_ext = CMP_W'(r_ring_size);
    assign n_eff    = (ring_ext == '0) ? CMP_W'(1) :
                      (ring_ext > CMP_W'(MAX_RING)) ? CMP_W'(MAX_RING) : ring_ext;
    assign last_cmp = n_eff - 1'b1;
    assign last_idx = last_cmp[IDX_W-1:0];
    assign single   = (n_eff == CMP_W'(1));

    assign who_cmp = CMP_W'(i_cmd.requester_index);
    assign who_ok  = who_cmp < n_eff;
    assign b_cmp   = (who_cmp == last_cmp) ? '0 : who_cmp + 1'b1;

    assign scan_cmp  = CMP_W'(r_scan_idx);
    assign gb_cmp    = (scan_cmp == last_cmp) ? '0 : scan_cmp + 1'b1;
    assign scan_last = (scan_cmp == last_cmp);

    assign holding_sel = |(who_hit & holding_vec);
    assign rel_ok      = (i_cmd.req_type == REQ_RELEASE) && holding_sel;
    assign any_grant   = |grant_vec;
    assign grant_en    = r_grants < GCNT_W'(MAX_RESULTS);

    assign tick_sum  = T_SUM_W'(r_tick) + T_SUM_W'(1);
    assign tick_inc  = (tick_sum > T_SUM_W'(TIME_MAX)) ? TIME_MAX : tick_sum[TIME_BITS-1:0];
    assign until_sum = T_SUM_W'(r_tick) + T_SUM_W'(r_cooldown);
    assign cool_end  = (until_sum > T_SUM_W'(TIME_MAX)) ? TIME_MAX : until_sum[TIME_BITS-1:0];

    assign new_res = '{granted_index: IDX_OUT_W'(r_scan_idx),
                       grant_time:    RES_TIME_W'(r_tick),
                       is_last:       1'b0};

    genvar j;
    generate
        for (j = 0; j < MAX_RING; j++) begin : g_cell
            t_cell_ctl            ctl;
            logic                 token_in;
            t_cell_stat           left_stat;
            t_cell_stat           right_stat;
            logic [TIME_BITS-1:0] left_key;
            logic [TIME_BITS-1:0] right_key;

            assign who_hit[j]     = who_ok && (who_cmp == CMP_W'(j));
            assign holding_vec[j] = stat_vec[j].holding;

            always_comb begin
                ctl.req      = accept && (i_cmd.req_type == REQ_ACQUIRE) && who_hit[j];
                ctl.rel      = accept && rel_ok && who_hit[j];
                ctl.free     = accept && rel_ok && (who_hit[j] || (CMP_W'(j) == b_cmp));
                ctl.take     = any_grant && (CMP_W'(j) == gb_cmp);
                ctl.single   = single;
                ctl.grant_en = grant_en;
                ctl.is_end   = (CMP_W'(j) == last_cmp);
            end

            // wrap the ring at the size in use
            if (j == 0) begin : g_left0
                assign token_in  = accept;
                assign left_stat = stat_vec[last_idx];
                assign left_key  = key_vec[last_idx];
            end else begin : g_leftn
                assign token_in  = token_out[j-1];
                assign left_stat = stat_vec[j-1];
                assign left_key  = key_vec[j-1];
            end

            if (j == MAX_RING - 1) begin : g_right_end
                assign right_stat = stat_vec[0];
                assign right_key  = key_vec[0];
            end else begin : g_right_mid
                assign right_stat = ctl.is_end ? stat_vec[0] : stat_vec[j+1];
                assign right_key  = ctl.is_end ? key_vec[0]  : key_vec[j+1];
            end

            rra_cell #(
                .TIME_BITS(TIME_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_token      (token_in),
                .o_token      (token_out[j]),
                .i_sched_mode (r_sched_mode),
                .i_burnout    (r_burnout),
                .i_comp_limit (r_comp_limit),
                .i_tick       (r_tick),
                .i_until      (cool_end),
                .i_left_stat  (left_stat),
                .i_right_stat (right_stat),
                .i_left_key   (left_key),
                .i_right_key  (right_key),
                .o_stat       (stat_vec[j]),
                .o_key        (key_vec[j]),
                .o_grant      (grant_vec[j])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_scan_idx   <= '0;
            r_grants     <= '0;
            r_tick       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_sched_mode <= RST_SCHED_MODE;
            r_cooldown   <= RST_COOLDOWN;
            r_burnout    <= RST_BURNOUT;
            r_ring_size  <= RST_RING_SIZE;
            r_comp_limit <= RST_COMP_LIMIT;
        end else begin
            // push the held grant out on the next grant or at the flush
            r_out_valid <= r_pend_valid &&
                           (((r_state == ST_SCAN) && any_grant) || (r_state == ST_FLUSH));
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state    <= ST_SCAN;
                        r_scan_idx <= '0;
                        r_grants   <= '0;
                        if (i_cmd.req_type == REQ_TICK) begin
                            r_tick <= tick_inc;
                        end
                    end
                end
                ST_SCAN: begin
                    // hold each grant back in r_pend until it is known whether it is last
                    if (any_grant) begin
                        r_grants     <= r_grants + 1'b1;
                        r_pend_valid <= 1'b1;
                    end
                    if (scan_last) begin
                        r_state <= ST_FLUSH;
                    end else begin
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end
                end
                ST_FLUSH: begin
                    r_pend_valid <= 1'b0;
                    r_state      <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCHED_MODE: r_sched_mode <= i_cfg_data[0];
                    CFG_COOLDOWN:   r_cooldown   <= i_cfg_data[COOL_W-1:0];
                    CFG_BURNOUT:    r_burnout    <= i_cfg_data[BURN_W-1:0];
                    CFG_RING_SIZE:  r_ring_size  <= i_cfg_data[RING_W-1:0];
                    CFG_COMP_LIMIT: r_comp_limit <= i_cfg_data[COMP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SCAN) && any_grant) begin
            r_pend <= new_res;
            r_out  <= r_pend;
        end else if (r_state == ST_FLUSH) begin
            r_out <= '{granted_index: r_pend.granted_index,
                       grant_time:    r_pend.grant_time,
                       is_last:       1'b1};
        end
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == ST_SCAN || $past(r_state) == ST_FLUSH))
        else $error("result strobe outside a scan");

    a_one_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(grant_vec))
        else $error("more than one cell granted in a cycle");

    a_grant_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        any_grant |-> (r_state == ST_SCAN))
        else $error("grant outside the scan");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.is_last) |=> !o_strobe)
        else $error("result right after the last item of a scan");

endmodule
